@@ design/lhc_pkg.sv @@
// Shared types and constants of the link handshake controller.
package lhc_pkg;

	localparam int unsigned ID_W      = 32;
	localparam int unsigned TO_W      = 16;
	localparam int unsigned MODE_W    = 2;
	localparam int unsigned LS_W      = 2;
	localparam int unsigned CFG_IDX_W = 8;

	localparam int unsigned TIMER_WIDTH_DEF = 16;

	// frame operation codes
	localparam logic [ID_W-1:0] OPCODE_REQUEST = 32'd1;
	localparam logic [ID_W-1:0] OPCODE_REPLY   = 32'd2;
	localparam logic [ID_W-1:0] OPCODE_CONFIRM = 32'd3;

	localparam logic [TO_W-1:0] TIMEOUT_RESET = 16'd1000;

	// item modes
	localparam logic [MODE_W-1:0] MODE_FRAME   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CONNECT = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TICK    = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LOCAL_ID   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PARTNER_ID = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAGIC      = 8'd3;

	// link_state encoding
	localparam logic [LS_W-1:0] LS_IDLE = 2'd0;
	localparam logic [LS_W-1:0] LS_REQ  = 2'd1;
	localparam logic [LS_W-1:0] LS_REP  = 2'd2;
	localparam logic [LS_W-1:0] LS_LINK = 2'd3;

	// queue between front and back
	localparam int unsigned Q_DEPTH = 2;
	localparam int unsigned Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

	typedef enum logic [2:0] {
		K_NONE    = 3'd0,
		K_REJECT  = 3'd1,
		K_CONNECT = 3'd2,
		K_TICK    = 3'd3,
		K_REQUEST = 3'd4,
		K_REPLY   = 3'd5,
		K_CONFIRM = 3'd6
	} kind_t;

	typedef struct packed {
		logic [ID_W-1:0] local_id;
		logic [ID_W-1:0] partner_id;
		logic [ID_W-1:0] magic_word;
		logic [TO_W-1:0] timeout_ticks;
	} cfg_t;

	// classified word handed from front to back
	typedef struct packed {
		kind_t           kind;
		logic            match;
		logic [ID_W-1:0] tx_sender;
		logic [ID_W-1:0] tx_target;
	} cls_t;

	typedef struct packed {
		logic            send_valid;
		logic [ID_W-1:0] send_opcode;
		logic [ID_W-1:0] send_sender_id;
		logic [ID_W-1:0] send_target_id;
		logic [LS_W-1:0] link_state;
		logic            connect_refused;
		logic            frame_rejected;
		logic            timeout_event;
	} res_t;

endpackage

@@ design/lhc_if.sv @@
// Channel interfaces: input items, results and configuration writes.
interface lhc_item_if;
	logic                      valid;
	logic                      ready;
	logic [lhc_pkg::MODE_W-1:0] mode;
	logic [lhc_pkg::ID_W-1:0]   head_word;
	logic [lhc_pkg::ID_W-1:0]   opcode_word;
	logic [lhc_pkg::ID_W-1:0]   sender_id;
	logic [lhc_pkg::ID_W-1:0]   target_id;
	logic [lhc_pkg::ID_W-1:0]   tail_word;

	modport source (output valid, mode, head_word, opcode_word, sender_id, target_id,
		tail_word, input ready);
	modport sink (input valid, mode, head_word, opcode_word, sender_id, target_id,
		tail_word, output ready);
endinterface

interface lhc_result_if;
	logic                     valid;
	logic                     ready;
	logic                     send_valid;
	logic [lhc_pkg::ID_W-1:0] send_opcode;
	logic [lhc_pkg::ID_W-1:0] send_sender_id;
	logic [lhc_pkg::ID_W-1:0] send_target_id;
	logic [lhc_pkg::LS_W-1:0] link_state;
	logic                     connect_refused;
	logic                     frame_rejected;
	logic                     timeout_event;

	modport source (output valid, send_valid, send_opcode, send_sender_id, send_target_id,
		link_state, connect_refused, frame_rejected, timeout_event, input ready);
	modport sink (input valid, send_valid, send_opcode, send_sender_id, send_target_id,
		link_state, connect_refused, frame_rejected, timeout_event, output ready);
endinterface

interface lhc_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [lhc_pkg::CFG_IDX_W-1:0] idx;
	logic [lhc_pkg::ID_W-1:0]      data;

	modport source (output valid, idx, data, input ready);
	modport sink (input valid, idx, data, output ready);
endinterface

@@ design/lhc_front.sv @@
// Front end: checks and classifies each input word, no handshake state needed.
module lhc_front (
	input  lhc_pkg::cfg_t         cfg,
	input  logic [lhc_pkg::MODE_W-1:0] mode,
	input  logic [lhc_pkg::ID_W-1:0]   head_word,
	input  logic [lhc_pkg::ID_W-1:0]   opcode_word,
	input  logic [lhc_pkg::ID_W-1:0]   sender_id,
	input  logic [lhc_pkg::ID_W-1:0]   target_id,
	input  logic [lhc_pkg::ID_W-1:0]   tail_word,
	output lhc_pkg::cls_t         cls
);
	import lhc_pkg::*;

	logic magic_ok;
	logic for_us;

	assign magic_ok = (head_word == cfg.magic_word) && (tail_word == cfg.magic_word);
	assign for_us   = (target_id == cfg.local_id);

	always_comb begin
		cls.kind      = K_NONE;
		cls.match     = (sender_id == cfg.partner_id);
		// frames answer with the ids swapped
		cls.tx_sender = target_id;
		cls.tx_target = sender_id;
		case (mode)
			MODE_FRAME: begin
				if (!magic_ok) begin
					cls.kind = K_REJECT;
				end else if (for_us) begin
					// priority order request, reply, confirm
					if (opcode_word == OPCODE_REQUEST) begin
						cls.kind = K_REQUEST;
					end else if (opcode_word == OPCODE_REPLY) begin
						cls.kind = K_REPLY;
					end else if (opcode_word == OPCODE_CONFIRM) begin
						cls.kind = K_CONFIRM;
					end
				end
			end
			MODE_CONNECT: begin
				cls.kind      = K_CONNECT;
				cls.tx_sender = cfg.local_id;
				cls.tx_target = cfg.partner_id;
			end
			MODE_TICK: begin
				cls.kind = K_TICK;
			end
			default: begin
				cls.kind = K_NONE;
			end
		endcase
	end

endmodule

@@ design/lhc_queue.sv @@
// Short FIFO of classified words between front and back.
module lhc_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  lhc_pkg::cls_t din,
	output logic          full,
	input  logic          pop,
	output lhc_pkg::cls_t dout,
	output logic          empty
);
	import lhc_pkg::*;

	cls_t               mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign empty = (cnt_q == '0);
	assign dout  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

@@ design/lhc_back.sv @@
// Back end: handshake state machine, timeout timer and result register.
module lhc_back #(
	parameter int unsigned TIMER_WIDTH = lhc_pkg::TIMER_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [lhc_pkg::TO_W-1:0] timeout_ticks,
	input  logic                     q_empty,
	input  lhc_pkg::cls_t            q_word,
	output logic                     q_pop,
	output logic                     res_valid,
	input  logic                     res_ready,
	output lhc_pkg::res_t            res
);
	import lhc_pkg::*;

	localparam int unsigned LW = (TIMER_WIDTH > TO_W) ? TIMER_WIDTH : TO_W;

	typedef enum logic [3:0] {
		HS_IDLE = 4'b0001,
		HS_REQ  = 4'b0010,
		HS_REP  = 4'b0100,
		HS_LINK = 4'b1000
	} hs_t;

	hs_t                    hs_q, hs_nx;
	logic [TIMER_WIDTH-1:0] cnt_q, cnt_nx, cnt_inc;
	logic                   run_q, run_nx;
	logic                   valid_q;
	res_t                   res_q, res_nx;
	logic                   pending;
	logic [TO_W-1:0]        limit;
	logic                   expire;

	assign pending = (hs_q == HS_REQ) || (hs_q == HS_REP);
	assign limit   = (timeout_ticks == '0) ? TO_W'(1) : timeout_ticks;
	assign cnt_inc = (cnt_q != '1) ? cnt_q + TIMER_WIDTH'(1) : cnt_q;
	assign expire  = (LW'(cnt_inc) >= LW'(limit)) || (cnt_inc == '1);

	// take a word when the result register is free or being drained
	assign q_pop     = !q_empty && (!valid_q || res_ready);
	assign res_valid = valid_q;
	assign res       = res_q;

	always_comb begin
		hs_nx  = hs_q;
		cnt_nx = cnt_q;
		run_nx = run_q;
		res_nx = '0;
		case (q_word.kind)
			K_REJECT: begin
				res_nx.frame_rejected = 1'b1;
			end
			K_CONNECT: begin
				if (pending) begin
					res_nx.connect_refused = 1'b1;
				end else begin
					res_nx.send_valid     = 1'b1;
					res_nx.send_opcode    = OPCODE_REQUEST;
					res_nx.send_sender_id = q_word.tx_sender;
					res_nx.send_target_id = q_word.tx_target;
					hs_nx  = HS_REQ;
					cnt_nx = '0;
					run_nx = 1'b1;
				end
			end
			K_REQUEST: begin
				if (!pending) begin
					if (q_word.match) begin
						res_nx.send_valid     = 1'b1;
						res_nx.send_opcode    = OPCODE_REPLY;
						res_nx.send_sender_id = q_word.tx_sender;
						res_nx.send_target_id = q_word.tx_target;
						hs_nx  = HS_REP;
						cnt_nx = '0;
						run_nx = 1'b1;
					end else begin
						hs_nx = HS_IDLE;
					end
				end
			end
			K_REPLY: begin
				if (hs_q == HS_REQ) begin
					cnt_nx = '0;
					run_nx = 1'b0;
					if (q_word.match) begin
						res_nx.send_valid     = 1'b1;
						res_nx.send_opcode    = OPCODE_CONFIRM;
						res_nx.send_sender_id = q_word.tx_sender;
						res_nx.send_target_id = q_word.tx_target;
						hs_nx = HS_LINK;
					end else begin
						hs_nx = HS_IDLE;
					end
				end
			end
			K_CONFIRM: begin
				if (hs_q == HS_REP) begin
					cnt_nx = '0;
					run_nx = 1'b0;
					hs_nx  = q_word.match ? HS_LINK : HS_IDLE;
				end
			end
			K_TICK: begin
				if (run_q) begin
					cnt_nx = cnt_inc;
					if (expire) begin
						cnt_nx = '0;
						run_nx = 1'b0;
						res_nx.timeout_event = 1'b1;
						if (pending) begin
							hs_nx = HS_IDLE;
						end
					end
				end
			end
			default: begin
				hs_nx = hs_q;
			end
		endcase
		case (hs_nx)
			HS_IDLE: res_nx.link_state = LS_IDLE;
			HS_REQ:  res_nx.link_state = LS_REQ;
			HS_REP:  res_nx.link_state = LS_REP;
			HS_LINK: res_nx.link_state = LS_LINK;
			default: res_nx.link_state = LS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hs_q    <= HS_IDLE;
			cnt_q   <= '0;
			run_q   <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				hs_q    <= hs_nx;
				cnt_q   <= cnt_nx;
				run_q   <= run_nx;
				valid_q <= 1'b1;
			end else if (res_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			res_q <= res_nx;
		end
	end

endmodule

@@ design/link_handshake_controller_unit.sv @@
// Top level of the link handshake controller.
// Runs the three-way request / reply / confirm handshake of one link interface.
// Each input word is a received frame, a connect command or a timer tick, and
// yields exactly one result word carrying any frame to transmit, the link state
// after the word and the refused / rejected / timeout flags. Throughput is one
// word per clock while the result sink is ready: the front end classifies a word
// in the cycle it is accepted (magic, target and partner compares against the
// configuration registers) and pushes it into a two-entry queue; the back end
// pops one word per cycle, when the result register is free or draining, into
// the state machine and timer and registers the result. When the result sink
// stalls the queue absorbs two more words before input ready drops. Configuration
// writes are always accepted (ready is tied high) and take effect for the next
// accepted word; write them only while no word is in flight. Writes to indexes
// beyond the four registers are ignored.
module link_handshake_controller_unit #(
	parameter int unsigned TIMER_WIDTH = lhc_pkg::TIMER_WIDTH_DEF
) (
	input logic       clk,
	input logic       arst_n,
	lhc_cfg_if.sink    cfg,
	lhc_item_if.sink   item,
	lhc_result_if.source result
);
	import lhc_pkg::*;

	cfg_t cfg_q;
	cls_t front_cls;
	cls_t q_word;
	res_t res;
	logic q_full;
	logic q_empty;
	logic q_pop;
	logic push;

	// configuration register file
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.local_id      <= '0;
			cfg_q.partner_id    <= '0;
			cfg_q.magic_word    <= '0;
			cfg_q.timeout_ticks <= TIMEOUT_RESET;
		end else if (cfg.valid) begin
			case (cfg.idx)
				REG_LOCAL_ID:   cfg_q.local_id      <= cfg.data;
				REG_PARTNER_ID: cfg_q.partner_id    <= cfg.data;
				REG_TIMEOUT:    cfg_q.timeout_ticks <= cfg.data[TO_W-1:0];
				REG_MAGIC:      cfg_q.magic_word    <= cfg.data;
				default:        cfg_q.local_id      <= cfg_q.local_id;
			endcase
		end
	end

	// front end: accept and classify
	assign item.ready = !q_full;
	assign push       = item.valid && !q_full;

	lhc_front u_front (
		.cfg         (cfg_q),
		.mode        (item.mode),
		.head_word   (item.head_word),
		.opcode_word (item.opcode_word),
		.sender_id   (item.sender_id),
		.target_id   (item.target_id),
		.tail_word   (item.tail_word),
		.cls         (front_cls)
	);

	lhc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (front_cls),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_word),
		.empty  (q_empty)
	);

	// back end: state machine, timer, result register
	lhc_back #(
		.TIMER_WIDTH (TIMER_WIDTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.timeout_ticks (cfg_q.timeout_ticks),
		.q_empty       (q_empty),
		.q_word        (q_word),
		.q_pop         (q_pop),
		.res_valid     (result.valid),
		.res_ready     (result.ready),
		.res           (res)
	);

	assign result.send_valid      = res.send_valid;
	assign result.send_opcode     = res.send_opcode;
	assign result.send_sender_id  = res.send_sender_id;
	assign result.send_target_id  = res.send_target_id;
	assign result.link_state      = res.link_state;
	assign result.connect_refused = res.connect_refused;
	assign result.frame_rejected  = res.frame_rejected;
	assign result.timeout_event   = res.timeout_event;

endmodule

@@ verif/lhc_checker.sv @@
// Link handshake checker: mirrors the handshake state and timer, compares each result word.
module lhc_checker #(
	parameter int unsigned TIMER_WIDTH = lhc_pkg::TIMER_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	lhc_cfg_if          cfg,
	lhc_item_if         item,
	lhc_result_if       result,
	output int unsigned fail_count,
	output int unsigned pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import lhc_pkg::*;

	localparam longint unsigned TMR_MAX = (64'd1 << TIMER_WIDTH) - 1;

	cfg_t                   cfg_shadow;
	logic [LS_W-1:0]        link_st;
	logic [TIMER_WIDTH-1:0] tmr_cnt;
	logic                   tmr_run;
	res_t                   expected_words[$];
	int unsigned            word_no;

	task automatic report_mismatch(string msg);
		if (fail_count < 100)
			$display("%0t ns: word %0d: %s", $time, word_no, msg);
		fail_count++;
	endtask

	task automatic cmp_field(string name, logic [ID_W-1:0] got, logic [ID_W-1:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	// advance the mirrored handshake by one input word, return its result word
	function automatic res_t next_word(logic [MODE_W-1:0] mode, logic [ID_W-1:0] head,
		logic [ID_W-1:0] opc, logic [ID_W-1:0] snd, logic [ID_W-1:0] tgt,
		logic [ID_W-1:0] tail);
		res_t            r;
		logic            id_ok;
		longint unsigned limit;
		r = '0;
		id_ok = (snd == cfg_shadow.partner_id);
		case (mode)
			MODE_FRAME: begin
				if (head != cfg_shadow.magic_word || tail != cfg_shadow.magic_word) begin
					r.frame_rejected = 1'b1;
				end else if (tgt == cfg_shadow.local_id) begin
					if (opc == OPCODE_REQUEST) begin
						if (link_st != LS_REQ && link_st != LS_REP) begin
							if (id_ok) begin
								r.send_valid     = 1'b1;
								r.send_opcode    = OPCODE_REPLY;
								r.send_sender_id = tgt;
								r.send_target_id = snd;
								link_st = LS_REP;
								tmr_cnt = '0;
								tmr_run = 1'b1;
							end else begin
								link_st = LS_IDLE;
							end
						end
					end else if (opc == OPCODE_REPLY) begin
						if (link_st == LS_REQ) begin
							tmr_cnt = '0;
							tmr_run = 1'b0;
							if (id_ok) begin
								r.send_valid     = 1'b1;
								r.send_opcode    = OPCODE_CONFIRM;
								r.send_sender_id = tgt;
								r.send_target_id = snd;
								link_st = LS_LINK;
							end else begin
								link_st = LS_IDLE;
							end
						end
					end else if (opc == OPCODE_CONFIRM) begin
						if (link_st == LS_REP) begin
							tmr_cnt = '0;
							tmr_run = 1'b0;
							link_st = id_ok ? LS_LINK : LS_IDLE;
						end
					end
				end
			end
			MODE_CONNECT: begin
				if (link_st == LS_REQ || link_st == LS_REP) begin
					r.connect_refused = 1'b1;
				end else begin
					r.send_valid     = 1'b1;
					r.send_opcode    = OPCODE_REQUEST;
					r.send_sender_id = cfg_shadow.local_id;
					r.send_target_id = cfg_shadow.partner_id;
					link_st = LS_REQ;
					tmr_cnt = '0;
					tmr_run = 1'b1;
				end
			end
			MODE_TICK: begin
				if (tmr_run) begin
					// zero timeout acts as one tick
					limit = (cfg_shadow.timeout_ticks == '0) ? 64'd1 :
						longint'(cfg_shadow.timeout_ticks);
					if (tmr_cnt < TMR_MAX)
						tmr_cnt++;
					if (tmr_cnt >= limit || tmr_cnt == TMR_MAX) begin
						tmr_cnt = '0;
						tmr_run = 1'b0;
						if (link_st == LS_REQ || link_st == LS_REP)
							link_st = LS_IDLE;
						r.timeout_event = 1'b1;
					end
				end
			end
			default: ;
		endcase
		r.link_state = link_st;
		return r;
	endfunction

	task automatic check_word(res_t got);
		res_t want;
		if (expected_words.size() == 0) begin
			report_mismatch("result word with none expected");
		end else begin
			want = expected_words.pop_front();
			cmp_field("send_valid", ID_W'(got.send_valid), ID_W'(want.send_valid));
			cmp_field("send_opcode", got.send_opcode, want.send_opcode);
			cmp_field("send_sender_id", got.send_sender_id, want.send_sender_id);
			cmp_field("send_target_id", got.send_target_id, want.send_target_id);
			cmp_field("link_state", ID_W'(got.link_state), ID_W'(want.link_state));
			cmp_field("connect_refused", ID_W'(got.connect_refused),
				ID_W'(want.connect_refused));
			cmp_field("frame_rejected", ID_W'(got.frame_rejected),
				ID_W'(want.frame_rejected));
			cmp_field("timeout_event", ID_W'(got.timeout_event),
				ID_W'(want.timeout_event));
		end
		word_no++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_shadow.local_id      = '0;
			cfg_shadow.partner_id    = '0;
			cfg_shadow.magic_word    = '0;
			cfg_shadow.timeout_ticks = TIMEOUT_RESET;
			link_st = LS_IDLE;
			tmr_cnt = '0;
			tmr_run = 1'b0;
			expected_words.delete();
			pending    = 0;
			fail_count = 0;
			word_no    = 0;
		end else begin
			if (result.valid && result.ready)
				check_word({result.send_valid, result.send_opcode, result.send_sender_id,
					result.send_target_id, result.link_state, result.connect_refused,
					result.frame_rejected, result.timeout_event});
			if (item.valid && item.ready)
				expected_words.push_back(next_word(item.mode, item.head_word,
					item.opcode_word, item.sender_id, item.target_id, item.tail_word));
			// register writes apply from the next word on
			if (cfg.valid && cfg.ready) begin
				case (cfg.idx)
					REG_LOCAL_ID:   cfg_shadow.local_id      = cfg.data;
					REG_PARTNER_ID: cfg_shadow.partner_id    = cfg.data;
					REG_TIMEOUT:    cfg_shadow.timeout_ticks = cfg.data[TO_W-1:0];
					REG_MAGIC:      cfg_shadow.magic_word    = cfg.data;
					default: ;
				endcase
			end
			pending = expected_words.size();
		end
	end

endmodule

@@ verif/tb_link_handshake_controller_unit.sv @@
// Testbench top: drives items, stalls and register writes, gives the verdict.
module tb_link_handshake_controller_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import lhc_pkg::*;

	localparam int unsigned TIMER_W = TIMER_WIDTH_DEF;
	// mode code the block ignores
	localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;
	// top of the register index space, past the last real register
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_TOP = 8'hFF;
	localparam int unsigned PHASE_WORDS = 225;
	localparam int unsigned N_PHASES    = 6;
	localparam int unsigned IDLE_LIMIT  = 2000;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [ID_W-1:0]   head;
		logic [ID_W-1:0]   opc;
		logic [ID_W-1:0]   snd;
		logic [ID_W-1:0]   tgt;
		logic [ID_W-1:0]   tail;
	} item_word_t;

	logic clk;
	logic arst_n;

	lhc_cfg_if    cfg_ch();
	lhc_item_if   item_ch();
	lhc_result_if res_ch();

	int unsigned fails;
	int unsigned pending_words;

	// local copy of the register settings, used to build well-formed frames
	logic [ID_W-1:0] cfg_local;
	logic [ID_W-1:0] cfg_partner;
	logic [ID_W-1:0] cfg_magic;
	logic [TO_W-1:0] cfg_timeout;

	int unsigned phase_count;
	int unsigned send_calm;
	int unsigned recv_calm;
	int unsigned recv_stall;

	link_handshake_controller_unit #(
		.TIMER_WIDTH(TIMER_W)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.item   (item_ch),
		.result (res_ch)
	);

	lhc_checker #(
		.TIMER_WIDTH(TIMER_W)
	) chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_ch),
		.item       (item_ch),
		.result     (res_ch),
		.fail_count (fails),
		.pending    (pending_words)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// --- word builders ---------------------------------------------------

	// frame with correct magic in both head and tail
	function automatic item_word_t frame_word(logic [ID_W-1:0] opc, logic [ID_W-1:0] snd,
		logic [ID_W-1:0] tgt);
		item_word_t w;
		w.mode = MODE_FRAME;
		w.head = cfg_magic;
		w.opc  = opc;
		w.snd  = snd;
		w.tgt  = tgt;
		w.tail = cfg_magic;
		return w;
	endfunction

	// connect / tick / ignored mode; frame fields carry junk that must not matter
	function automatic item_word_t ctl_word(logic [MODE_W-1:0] mode);
		item_word_t w;
		w.mode = mode;
		w.head = $urandom();
		w.opc  = $urandom();
		w.snd  = $urandom();
		w.tgt  = $urandom();
		w.tail = $urandom();
		return w;
	endfunction

	function automatic logic [ID_W-1:0] pick_opcode();
		case ($urandom_range(0, 2))
			0:       return OPCODE_REQUEST;
			1:       return OPCODE_REPLY;
			default: return OPCODE_CONFIRM;
		endcase
	endfunction

	// mostly the expected partner, sometimes a stranger
	function automatic logic [ID_W-1:0] pick_sender();
		return ($urandom_range(0, 99) < 85) ? cfg_partner : $urandom();
	endfunction

	function automatic logic [ID_W-1:0] nonzero_mask();
		logic [ID_W-1:0] m;
		m = $urandom();
		return (m == '0) ? 1 : m;
	endfunction

	// words that are mostly rejected or ignored; a random mode may also give a connect or tick
	function automatic item_word_t noise_word();
		item_word_t w;
		int unsigned sel;
		w = frame_word(pick_opcode(), pick_sender(), cfg_local);
		case ($urandom_range(0, 4))
			0: begin
				// bad magic in head, tail or both
				sel = $urandom_range(0, 2);
				if (sel != 1) w.head = cfg_magic ^ nonzero_mask();
				if (sel != 0) w.tail = cfg_magic ^ nonzero_mask();
			end
			1: w.tgt = cfg_local ^ nonzero_mask();
			2: w.opc = $urandom();
			3: w = ctl_word(MODE_NONE);
			default: begin
				w = ctl_word(MODE_FRAME);
				w.mode = MODE_W'($urandom_range(0, 3));
			end
		endcase
		return w;
	endfunction

	// --- pacing ----------------------------------------------------------

	// sender gap: mostly none or short, a few long, some calm stretches
	function automatic int unsigned next_gap();
		int unsigned r;
		if (send_calm > 0) begin
			send_calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 65) begin
			send_calm = $urandom_range(20, 120);
			return 0;
		end
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(8, 50);
	endfunction

	// result ready: one assignment per falling edge
	initial begin
		res_ch.ready = 1'b0;
		recv_calm  = 0;
		recv_stall = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (recv_stall > 0) begin
				res_ch.ready <= 1'b0;
				recv_stall--;
			end else begin
				res_ch.ready <= 1'b1;
				if (recv_calm > 0) begin
					recv_calm--;
				end else begin
					case ($urandom_range(0, 99)) inside
						[0:59]:  ;
						[60:69]: recv_calm  = $urandom_range(20, 100);
						[70:96]: recv_stall = $urandom_range(1, 3);
						default: recv_stall = $urandom_range(10, 40);
					endcase
				end
			end
		end
	end

	// --- channel drivers -------------------------------------------------

	// called at a falling edge; leaves valid high so back-to-back words never toggle it
	task automatic send_item(item_word_t w);
		item_ch.valid       <= 1'b1;
		item_ch.mode        <= w.mode;
		item_ch.head_word   <= w.head;
		item_ch.opcode_word <= w.opc;
		item_ch.sender_id   <= w.snd;
		item_ch.target_id   <= w.tgt;
		item_ch.tail_word   <= w.tail;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic put_word(item_word_t w);
		int unsigned gap;
		send_item(w);
		phase_count++;
		gap = next_gap();
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ID_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.idx   <= idx;
		cfg_ch.data  <= data;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	// drain, then rewrite all registers plus one unmapped index
	task automatic configure(logic [ID_W-1:0] lid, logic [ID_W-1:0] pid,
		logic [TO_W-1:0] tmo, logic [ID_W-1:0] magic, logic [CFG_IDX_W-1:0] spare);
		logic [ID_W-1:0] tmo_data;
		item_ch.valid <= 1'b0;
		while (pending_words != 0) @(negedge clk);
		// upper bits of the timeout write are junk and must be dropped
		tmo_data = $urandom();
		tmo_data[TO_W-1:0] = tmo;
		write_reg(REG_MAGIC, magic);
		write_reg(REG_LOCAL_ID, lid);
		write_reg(spare, $urandom());
		write_reg(REG_TIMEOUT, tmo_data);
		write_reg(REG_PARTNER_ID, pid);
		cfg_ch.valid <= 1'b0;
		cfg_local   = lid;
		cfg_partner = pid;
		cfg_timeout = tmo;
		cfg_magic   = magic;
	endtask

	// ticks between handshake steps; with a short timeout, often enough to expire
	task automatic tick_burst();
		int unsigned eff;
		int unsigned n;
		eff = (cfg_timeout == '0) ? 1 : cfg_timeout;
		n = (eff <= 12) ? $urandom_range(0, eff + 1) : $urandom_range(0, 3);
		repeat (n) put_word(ctl_word(MODE_TICK));
	endtask

	task automatic random_step();
		case ($urandom_range(0, 99)) inside
			[0:34]: begin
				// we start the handshake
				put_word(ctl_word(MODE_CONNECT));
				tick_burst();
				put_word(frame_word(OPCODE_REPLY, pick_sender(), cfg_local));
			end
			[35:69]: begin
				// remote starts the handshake
				put_word(frame_word(OPCODE_REQUEST, pick_sender(), cfg_local));
				tick_burst();
				put_word(frame_word(OPCODE_CONFIRM, pick_sender(), cfg_local));
			end
			[70:79]: begin
				// collisions and out-of-order steps
				if ($urandom_range(0, 1))
					put_word(ctl_word(MODE_CONNECT));
				else
					put_word(frame_word(OPCODE_REQUEST, pick_sender(), cfg_local));
				if ($urandom_range(0, 3) == 0)
					put_word(ctl_word(MODE_CONNECT));
				else
					put_word(frame_word(pick_opcode(), pick_sender(), cfg_local));
			end
			default: put_word(noise_word());
		endcase
	endtask

	// --- watchdog: cycles with no handshake on any channel -----------------
	initial begin
		int unsigned idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	// --- main stimulus -------------------------------------------------------
	initial begin
		item_word_t  w;
		logic [ID_W-1:0] lid;
		logic [ID_W-1:0] pid;
		logic [ID_W-1:0] magic;
		logic [TO_W-1:0] tmo;
		logic [CFG_IDX_W-1:0] spare;

		arst_n = 1'b0;
		item_ch.valid       = 1'b0;
		item_ch.mode        = MODE_FRAME;
		item_ch.head_word   = '0;
		item_ch.opcode_word = '0;
		item_ch.sender_id   = '0;
		item_ch.target_id   = '0;
		item_ch.tail_word   = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.idx   = REG_LOCAL_ID;
		cfg_ch.data  = '0;
		send_calm   = 0;
		phase_count = 0;
		// reset values of the registers
		cfg_local   = '0;
		cfg_partner = '0;
		cfg_magic   = '0;
		cfg_timeout = TIMEOUT_RESET;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: reset settings, ids and magic all zero
		put_word(ctl_word(MODE_TICK));                 // tick with timer stopped
		w = '1;
		w.mode = MODE_NONE;
		put_word(w);                                   // ignored mode, all ones
		w = frame_word(OPCODE_REQUEST, '0, '0);
		w.head = '1;
		put_word(w);                                   // bad head
		w = frame_word(OPCODE_REQUEST, '0, '0);
		w.tail = '1;
		put_word(w);                                   // bad tail
		put_word(frame_word(OPCODE_REQUEST, '0, '1));  // foreign target
		put_word(frame_word('1, '0, '0));              // unknown opcode
		put_word(frame_word(OPCODE_REPLY, '0, '0));    // reply while idle
		put_word(frame_word(OPCODE_CONFIRM, '0, '0));  // confirm while idle
		put_word(frame_word(OPCODE_REQUEST, '0, '0));  // -> reply sent
		put_word(ctl_word(MODE_CONNECT));              // refused, pending
		put_word(frame_word(OPCODE_REQUEST, '0, '0));  // ignored, pending
		put_word(ctl_word(MODE_TICK));
		put_word(frame_word(OPCODE_CONFIRM, '1, '0));  // stranger confirms -> idle
		put_word(frame_word(OPCODE_REQUEST, '0, '0));
		put_word(frame_word(OPCODE_CONFIRM, '0, '0));  // -> linked
		put_word(ctl_word(MODE_CONNECT));              // reconnect from linked
		put_word(ctl_word(MODE_CONNECT));              // refused
		put_word(frame_word(OPCODE_REPLY, '1, '0));    // stranger replies -> idle
		put_word(ctl_word(MODE_CONNECT));
		put_word(frame_word(OPCODE_REPLY, '0, '0));    // -> confirm, linked
		put_word(frame_word(OPCODE_REQUEST, '1, '0));  // stranger request drops link
		put_word(ctl_word(MODE_CONNECT));
		put_word(ctl_word(MODE_TICK));
		put_word(ctl_word(MODE_TICK));

		for (int p = 0; p < N_PHASES; p++) begin
			lid   = $urandom();
			pid   = $urandom();
			magic = $urandom();
			spare = CFG_IDX_W'($urandom_range(4, 254));
			case (p)
				0: begin
					lid = '1; pid = '0; tmo = 1; magic = '1; spare = REG_SPARE_TOP;
				end
				1: tmo = 0;                     // zero timeout behaves as one
				2: begin
					tmo = 3; magic = '0;
				end
				3: begin
					lid = '0; pid = '1; tmo = '1;
				end
				4: begin
					pid = lid; tmo = TO_W'($urandom_range(2, 8));
				end
				default: tmo = TO_W'($urandom_range(4, 12));
			endcase
			configure(lid, pid, tmo, magic, spare);

			phase_count = 0;
			while (phase_count < PHASE_WORDS) random_step();
		end

		// drain and let the pipeline settle
		item_ch.valid <= 1'b0;
		while (pending_words != 0) @(negedge clk);
		repeat (8) @(posedge clk);

		if (fails == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ filelist.f @@
design/lhc_pkg.sv
design/lhc_if.sv
design/lhc_front.sv
design/lhc_queue.sv
design/lhc_back.sv
design/link_handshake_controller_unit.sv
verif/lhc_checker.sv
verif/tb_link_handshake_controller_unit.sv
